/* design/doiq_pkg.sv */
// ----------------------------------------------------------------------------
// doiq_pkg
// Shared types and codes for the drop-oldest IQ block queue.
// ----------------------------------------------------------------------------
package doiq_pkg;

   localparam int REQ_W = 136;
   localparam int RSP_W = 144;

   localparam logic [29:0] NS_PER_S = 30'd1000000000;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_FAIL  = 3'd2,
      OP_RESET = 3'd3,
      OP_PUSH  = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   localparam logic [3:0] ST_SAMPLES  = 4'd0;
   localparam logic [3:0] ST_TIMEOUT  = 4'd1;
   localparam logic [3:0] ST_STOPPED  = 4'd2;
   localparam logic [3:0] ST_ERROR    = 4'd3;
   localparam logic [3:0] ST_ACCEPTED = 4'd4;
   localparam logic [3:0] ST_DROPPED  = 4'd5;
   localparam logic [3:0] ST_REFUSED  = 4'd6;
   localparam logic [3:0] ST_INVALID  = 4'd7;
   localparam logic [3:0] ST_OVERFLOW = 4'd8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_CHK,
      S_ADDR,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic acc;
      logic mul;
      logic div;
      logic chk;
      logic addr;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic rd_slow;
      logic off_zero;
      logic div_done;
      logic ovf;
      logic last_smp;
   } sts_type;

   typedef struct packed {
      logic [3:0]         status;
      logic signed [15:0] out_i;
      logic signed [15:0] out_q;
      logic               out_valid;
      logic signed [63:0] first_time_ns;
      logic               time_valid;
      logic [6:0]         delivered;
      logic               last;
      logic               is_running;
      logic [3:0]         queued;
      logic [31:0]        drop_total;
   } rsp_type;

endpackage

/* design/doiq_ctrl.sv */
// ----------------------------------------------------------------------------
// doiq_ctrl
// Sequencer: accepts transactions and steps a read through divide and emit.
// ----------------------------------------------------------------------------
module doiq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  doiq_pkg::sts_type sts,
   output doiq_pkg::cmd_type cmd
);
   import doiq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && sts.out_free && sts.rd_slow) begin
               state_in = sts.off_zero ? S_CHK : S_MUL;
            end
         end
         S_MUL: state_in = S_DIV;
         S_DIV: begin
            if (sts.div_done) state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.out_free) state_in = sts.ovf ? S_IDLE : S_ADDR;
         end
         S_ADDR: state_in = S_EMIT;
         S_EMIT: begin
            if (sts.out_free) state_in = sts.last_smp ? S_IDLE : S_ADDR;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = sts.out_free;
            cmd.acc    = req_tvalid && sts.out_free;
         end
         S_MUL:  cmd.mul  = 1'b1;
         S_DIV:  cmd.div  = !sts.div_done;
         S_CHK:  cmd.chk  = sts.out_free;
         S_ADDR: cmd.addr = 1'b1;
         S_EMIT: cmd.emit = sts.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

/* design/doiq_dp.sv */
// ----------------------------------------------------------------------------
// doiq_dp
// Datapath: queue bookkeeping, sample store, offset divider, result register.
// ----------------------------------------------------------------------------
module doiq_dp #(
   parameter int QUEUE_BLOCKS      = 8,
   parameter int MAX_BLOCK_SAMPLES = 256,
   parameter int MAX_READ          = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  doiq_pkg::cmd_type         cmd,
   output doiq_pkg::sts_type         sts,
   input  logic [2:0]                req_op,
   input  logic                      req_end,
   input  logic signed [15:0]        req_i,
   input  logic signed [15:0]        req_q,
   input  logic signed [63:0]        req_time,
   input  logic [31:0]               req_rate,
   input  logic [6:0]                req_count,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output doiq_pkg::rsp_type         rsp
);
   import doiq_pkg::*;

   localparam int SLOTS = QUEUE_BLOCKS + 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(QUEUE_BLOCKS + 1);
   localparam int LW    = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int FW    = $clog2(MAX_BLOCK_SAMPLES + 2);
   localparam int NW    = $clog2(MAX_READ + 1);
   localparam int DEPTH = SLOTS * MAX_BLOCK_SAMPLES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = LW + 30;
   localparam int DCW   = $clog2(PW + 1);

   logic [31:0]        store_ff [DEPTH];
   logic [LW-1:0]      len_ff   [SLOTS];
   logic [LW-1:0]      off_ff   [SLOTS];
   logic [63:0]        stamp_ff [SLOTS];
   logic [31:0]        rate_ff  [SLOTS];

   logic [SW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           run_ff, run_in, fail_ff, fail_in;
   logic [31:0]    drop_ff, drop_in;
   logic           stg_zero_ff, stg_zero_in;
   logic [NW-1:0]  n_ff, n_in, k_ff, k_in;
   logic [PW-1:0]  quo_ff, quo_in;
   logic [31:0]    rem_ff, rem_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [63:0]    t_ff, t_in;
   logic [31:0]    rdata_ff;
   logic           rvalid_ff, rvalid_in;
   rsp_type        out_ff, out_in;

   logic [SW:0]    slot_sum;
   logic [SW-1:0]  stage;
   logic [SW-1:0]  head_inc;
   logic [LW-1:0]  len_h, off_h, off_new;
   logic           consume;
   logic [NW-1:0]  k_new;
   logic [6:0]     req_sat;
   logic [FW-1:0]  fill_after;
   logic           wr_smp, wr_meta, wr_cmt, rate_zero;
   logic [32:0]    rem_sh;
   logic [64:0]    t_sum;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic           out_free;
   op_type         op;

   assign op       = op_type'(req_op);
   assign out_free = !rvalid_ff || rsp_tready;

   always_comb begin
      slot_sum = (SW+1)'(head_ff) + (SW+1)'(count_ff);
      if (slot_sum >= (SW+1)'(SLOTS)) slot_sum = slot_sum - (SW+1)'(SLOTS);
   end
   assign stage    = slot_sum[SW-1:0];
   assign head_inc = (head_ff == SW'(SLOTS - 1)) ? '0 : head_ff + SW'(1);

   assign len_h   = len_ff[head_ff];
   assign off_h   = off_ff[head_ff];
   assign off_new = off_h + LW'(1);
   assign consume = off_new >= len_h;
   assign k_new   = k_ff + NW'(1);
   assign req_sat = (req_count > 7'(MAX_READ)) ? 7'(MAX_READ) : req_count;

   assign fill_after = (fill_ff < FW'(MAX_BLOCK_SAMPLES)) ? fill_ff + FW'(1)
                                                          : FW'(MAX_BLOCK_SAMPLES + 1);
   assign rate_zero  = (fill_ff == '0) ? (req_rate == '0) : stg_zero_ff;

   assign rem_sh = {rem_ff, quo_ff[PW-1]};
   assign t_sum  = {1'b0, stamp_ff[head_ff]} + 65'(quo_ff);

   assign wr_addr = AW'(stage) * AW'(MAX_BLOCK_SAMPLES) + AW'(fill_ff);
   assign rd_addr = AW'(head_ff) * AW'(MAX_BLOCK_SAMPLES) + AW'(off_h);

   always_comb begin
      sts.out_free = out_free;
      sts.rd_slow  = (op == OP_READ) && (req_sat != '0) && (count_ff != '0);
      sts.off_zero = (off_h == '0);
      sts.div_done = (dcnt_ff == '0);
      sts.ovf      = !t_sum[63 - 0] ? 1'b0 : !stamp_ff[head_ff][63];
      sts.last_smp = (k_new == n_ff) || (consume && count_ff == CW'(1));
   end

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      fill_in     = fill_ff;
      run_in      = run_ff;
      fail_in     = fail_ff;
      drop_in     = drop_ff;
      stg_zero_in = stg_zero_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      dcnt_in     = dcnt_ff;
      t_in        = t_ff;
      wr_smp      = 1'b0;
      wr_meta     = 1'b0;
      wr_cmt      = 1'b0;
      rvalid_in   = rvalid_ff && !rsp_tready;
      out_in      = out_ff;
      out_in.out_i         = '0;
      out_in.out_q         = '0;
      out_in.out_valid     = 1'b0;
      out_in.first_time_ns = '0;
      out_in.time_valid    = 1'b0;
      out_in.delivered     = '0;
      out_in.last          = 1'b1;

      if (cmd.acc) begin
         case (op)
            OP_START: begin
               head_in = '0; count_in = '0; fill_in = '0;
               run_in = 1'b1; fail_in = 1'b0; drop_in = '0;
            end
            OP_STOP: run_in = 1'b0;
            OP_FAIL: begin
               run_in = 1'b0; fail_in = 1'b1;
            end
            OP_RESET: begin
               head_in = '0; count_in = '0; fill_in = '0;
               run_in = 1'b0; fail_in = 1'b0; drop_in = '0;
            end
            OP_PUSH: begin
               if (fill_ff == '0) begin
                  wr_meta     = 1'b1;
                  stg_zero_in = (req_rate == '0);
               end
               wr_smp = (fill_ff < FW'(MAX_BLOCK_SAMPLES));
               if (req_end) begin
                  fill_in   = '0;
                  rvalid_in = 1'b1;
                  if (fill_after > FW'(MAX_BLOCK_SAMPLES) || rate_zero) begin
                     out_in.status = ST_INVALID;
                  end else if (!run_ff || fail_ff) begin
                     out_in.status = ST_REFUSED;
                  end else begin
                     wr_cmt = 1'b1;
                     if (count_ff >= CW'(QUEUE_BLOCKS)) begin
                        head_in       = head_inc;
                        drop_in       = (drop_ff == '1) ? drop_ff : drop_ff + 32'd1;
                        out_in.status = ST_DROPPED;
                     end else begin
                        count_in      = count_ff + CW'(1);
                        out_in.status = ST_ACCEPTED;
                     end
                  end
               end else begin
                  fill_in = fill_after;
               end
            end
            OP_READ: begin
               n_in   = NW'(req_sat);
               k_in   = '0;
               quo_in = '0;
               if (req_sat == '0) begin
                  rvalid_in     = 1'b1;
                  out_in.status = ST_SAMPLES;
               end else if (count_ff == '0) begin
                  rvalid_in     = 1'b1;
                  out_in.status = fail_ff ? ST_ERROR : (run_ff ? ST_TIMEOUT : ST_STOPPED);
               end
            end
            default: ;
         endcase
      end

      if (cmd.mul) begin
         quo_in  = PW'(off_h) * PW'(NS_PER_S);
         rem_in  = '0;
         dcnt_in = DCW'(PW);
      end

      // one restoring divide step a cycle
      if (cmd.div) begin
         dcnt_in = dcnt_ff - DCW'(1);
         if (rem_sh >= {1'b0, rate_ff[head_ff]}) begin
            rem_in = 32'(rem_sh - {1'b0, rate_ff[head_ff]});
            quo_in = {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[PW-2:0], 1'b0};
         end
      end

      if (cmd.chk) begin
         if (sts.ovf) begin
            rvalid_in     = 1'b1;
            out_in.status = ST_OVERFLOW;
         end else begin
            t_in = t_sum[63:0];
         end
      end

      if (cmd.emit) begin
         k_in = k_new;
         if (consume) begin
            head_in  = head_inc;
            count_in = count_ff - CW'(1);
         end
         rvalid_in            = 1'b1;
         out_in.status        = ST_SAMPLES;
         out_in.out_i         = rdata_ff[15:0];
         out_in.out_q         = rdata_ff[31:16];
         out_in.out_valid     = 1'b1;
         out_in.first_time_ns = t_ff;
         out_in.time_valid    = (k_ff == '0);
         out_in.delivered     = 7'(k_new);
         out_in.last          = sts.last_smp;
      end

      out_in.is_running = run_in;
      out_in.queued     = 4'(count_in);
      out_in.drop_total = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         fill_ff   <= '0;
         run_ff    <= 1'b0;
         fail_ff   <= 1'b0;
         drop_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         fill_ff   <= fill_in;
         run_ff    <= run_in;
         fail_ff   <= fail_in;
         drop_ff   <= drop_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_zero_ff <= stg_zero_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      t_ff        <= t_in;
      if (!rvalid_ff || rsp_tready) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_smp) store_ff[wr_addr] <= {req_q, req_i};
      if (cmd.addr) rdata_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_meta) begin
         stamp_ff[stage] <= req_time;
         rate_ff[stage]  <= req_rate;
      end
      if (wr_cmt) begin
         len_ff[stage] <= LW'(fill_after);
         off_ff[stage] <= '0;
      end
      if (cmd.emit) off_ff[head_ff] <= off_new;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp        = out_ff;

endmodule

/* design/drop_oldest_iq_block_queue_top.sv */
// ----------------------------------------------------------------------------
// drop_oldest_iq_block_queue_top
// Bounded drop-oldest queue of timestamped IQ sample blocks with run state.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transaction: start, stop, fail, reset,
//   push one sample, or read. Pushes are taken one per cycle while the
//   sequencer is idle and the result register is free; the sample with
//   req_tlast set closes the block and yields one status transaction.
//   rsp_* returns results; rsp_tlast marks the final result of a request.
//   Control operations and pushes without req_tlast produce no result.
//   A read that finds samples first computes the time offset of the head
//   sample: a multiply, then a restoring divider running one quotient bit
//   per cycle (LW+30 bits, 39 at defaults) and a finishing step, when the
//   head block was partly read, skipped otherwise. A check step then tests
//   the time stamp for overflow. Each sample then takes a sample-store
//   read and a result load. Reset clears the queue, run and fail flags and
//   the drop count; the sample store and per-block tables hold garbage
//   until written. When the receiver stalls, hold the result register and
//   stop accepting requests; a read sequence pauses at its next result.
// ----------------------------------------------------------------------------
module drop_oldest_iq_block_queue_top #(
   parameter int QUEUE_BLOCKS      = 8,
   parameter int MAX_BLOCK_SAMPLES = 256,
   parameter int MAX_READ          = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // sample_i, sample_q, block_time_ns, rate_hz, request_count, pad
   input  logic [doiq_pkg::REQ_W-1:0]   req_tdata,
   // operation
   input  logic [2:0]                   req_tuser,
   // block_end
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // out_i, out_q, out_valid, first_time_ns, time_valid, delivered,
   // is_running, queued, drop_total, pad
   output logic [doiq_pkg::RSP_W-1:0]   rsp_tdata,
   // status
   output logic [3:0]                   rsp_tuser,
   // last
   output logic                         rsp_tlast
);
   import doiq_pkg::*;

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp;

   // sequencer
   doiq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // queue state, store and divider
   doiq_dp #(
      .QUEUE_BLOCKS      (QUEUE_BLOCKS),
      .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
      .MAX_READ          (MAX_READ)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_op     (req_tuser),
      .req_end    (req_tlast),
      .req_i      (req_tdata[15:0]),
      .req_q      (req_tdata[31:16]),
      .req_time   (req_tdata[95:32]),
      .req_rate   (req_tdata[127:96]),
      .req_count  (req_tdata[134:128]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp        (rsp)
   );

   // pack the result transaction
   assign rsp_tdata = {2'b00, rsp.drop_total, rsp.queued, rsp.is_running, rsp.delivered,
                       rsp.time_valid, rsp.first_time_ns, rsp.out_valid, rsp.out_q,
                       rsp.out_i};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

   // queue depth never exceeds its capacity
   a_queued_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[109:106] <= 4'(QUEUE_BLOCKS)))
      else $error("queued count above capacity");

   // time stamp only on the first delivered sample of a read
   a_time_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[97]) |-> (rsp_tdata[32] && rsp_tdata[104:98] == 7'd1))
      else $error("time_valid off the first sample");

   // status-only results always close their request
   a_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_SAMPLES) |-> rsp_tlast)
      else $error("non-sample result without last");

   // a sample is delivered only as a samples result
   a_sample_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |-> (rsp_tuser == ST_SAMPLES))
      else $error("sample carried with wrong status");

endmodule
